// ===== design/mip_pkg.sv =====
// ----------------------------------------------------------------------------
// mip_pkg
// Types and constants shared by the mip level layout calculator modules.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int unsigned DIM_W       = 30;
  localparam int unsigned DEP_W       = 27;
  localparam int unsigned LVL_W       = 4;
  localparam int unsigned CELL_STAGES = 12;

  typedef struct packed {
    logic [14:0] width;
    logic [14:0] height;
    logic [11:0] depth;
    logic [4:0]  bytes_per_texel;
    logic [3:0]  level_index;
    logic        is_3d;
    logic        upsampled;
  } mip_req_t;

  typedef struct packed {
    logic [63:0] level_offset;
    logic [63:0] row_stride;
    logic [63:0] image_stride;
  } mip_rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DEP_W-1:0] d;
    logic [4:0]       bpt;
    logic [LVL_W-1:0] lvl;
    logic             is_3d;
    logic             up;
    logic [63:0]      offset;
    logic [63:0]      row;
    logic [63:0]      img;
  } mip_item_t;

endpackage

// ===== design/mip_rnd.sv =====
// ----------------------------------------------------------------------------
// mip_rnd
// Three-stage round down to a multiple of ALIGN_BYTES: z = y - (y mod A).
// Byte folding, reciprocal multiply, one correction step.
// ----------------------------------------------------------------------------
module mip_rnd #(
  parameter int unsigned ALIGN_BYTES = 16
) (
  input  logic        clk_i,
  input  logic [63:0] y_i,
  output logic [63:0] z_o
);

  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [20:0] RECIP       = 21'((64'd1 << RECIP_SHIFT) / ALIGN_BYTES);
  localparam logic [8:0]  ALIGN_V     = 9'(ALIGN_BYTES);
  localparam logic [7:0]  FOLD_M [8]  = '{
    8'((64'd1 << 0)  % ALIGN_BYTES), 8'((64'd1 << 8)  % ALIGN_BYTES),
    8'((64'd1 << 16) % ALIGN_BYTES), 8'((64'd1 << 24) % ALIGN_BYTES),
    8'((64'd1 << 32) % ALIGN_BYTES), 8'((64'd1 << 40) % ALIGN_BYTES),
    8'((64'd1 << 48) % ALIGN_BYTES), 8'((64'd1 << 56) % ALIGN_BYTES)
  };

  logic [63:0] y_a_q, y_b_q, z_q;
  logic [18:0] s_a_d, s_a_q, s_b_q, q_b_d, q_b_q;
  logic [39:0] recip_prod;
  logic [18:0] qa, rem1, rem;

  always_comb begin
    s_a_d = '0;
    for (int k = 0; k < 8; k++) begin
      s_a_d = s_a_d + 19'(19'(y_i[8*k +: 8]) * 19'(FOLD_M[k]));
    end
  end

  assign recip_prod = 40'(s_a_q) * 40'(RECIP);
  assign q_b_d      = recip_prod[RECIP_SHIFT +: 19];

  // quotient estimate is low by at most one
  always_comb begin
    qa   = 19'(28'(q_b_q) * 28'(ALIGN_V));
    rem1 = s_b_q - qa;
    rem  = (rem1 >= 19'(ALIGN_V)) ? (rem1 - 19'(ALIGN_V)) : rem1;
  end

  always_ff @(posedge clk_i) begin
    y_a_q <= y_i;
    s_a_q <= s_a_d;
    y_b_q <= y_a_q;
    s_b_q <= s_a_q;
    q_b_q <= q_b_d;
    z_q   <= y_b_q - 64'(rem);
  end

  assign z_o = z_q;

endmodule

// ===== design/mip_cell.sv =====
// ----------------------------------------------------------------------------
// mip_cell
// One level of the chain: aligned row and image stride for the current
// dimensions, offset accumulation and dimension step for earlier levels.
// ----------------------------------------------------------------------------
module mip_cell #(
  parameter int unsigned ALIGN_BYTES = 16,
  parameter int unsigned CELL_IDX    = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  mip_pkg::mip_item_t item_i,
  output logic               vld_o,
  output mip_pkg::mip_item_t item_o
);

  import mip_pkg::*;

  localparam logic [4:0]  IDX      = 5'(CELL_IDX);
  localparam logic [63:0] ALIGN_M1 = 64'(ALIGN_BYTES - 1);

  function automatic logic [DIM_W-1:0] nxt_dim(input logic [DIM_W-1:0] v, input logic up);
    logic [DIM_W-1:0] n;
    n = up ? {v[DIM_W-2:0], 1'b0} : {1'b0, v[DIM_W-1:1]};
    if (n == '0) begin
      n = DIM_W'(1);
    end
    return n;
  endfunction

  logic [CELL_STAGES-1:0] vld_q;
  mip_item_t              pay_q [CELL_STAGES];
  mip_item_t              pay_d [CELL_STAGES];

  logic [34:0] row_raw;
  logic [63:0] y1_d, y1_q, y2_d, y2_q;
  logic [63:0] row_z, img_z;
  logic [47:0] pl_d, pl_q, ph_d, ph_q;
  logic [58:0] dl_d, dl_q;
  logic [31:0] dh_d, dh_q;
  logic [63:0] contrib_d, contrib_q;
  logic        advance;

  assign row_raw = 35'(item_i.w) * 35'(item_i.bpt);
  assign y1_d    = 64'(row_raw) + ALIGN_M1;

  mip_rnd #(.ALIGN_BYTES(ALIGN_BYTES)) u_rnd_row (
    .clk_i (clk_i),
    .y_i   (y1_q),
    .z_o   (row_z)
  );

  assign pl_d = 48'(pay_q[3].h) * 48'(row_z[17:0]);
  assign ph_d = 48'(pay_q[3].h) * 48'(row_z[35:18]);
  assign y2_d = 64'(pl_q) + {ph_q[45:0], 18'd0} + ALIGN_M1;

  mip_rnd #(.ALIGN_BYTES(ALIGN_BYTES)) u_rnd_img (
    .clk_i (clk_i),
    .y_i   (y2_q),
    .z_o   (img_z)
  );

  assign dl_d      = 59'(pay_q[8].d) * 59'(img_z[31:0]);
  assign dh_d      = 32'(pay_q[8].d) * img_z[63:32];
  assign contrib_d = 64'(dl_q) + {dh_q, 32'd0};
  assign advance   = IDX < {1'b0, pay_q[10].lvl};

  always_comb begin
    pay_d[0] = item_i;
    for (int k = 1; k < CELL_STAGES; k++) begin
      pay_d[k] = pay_q[k-1];
    end
    pay_d[4].row = row_z;
    pay_d[9].img = img_z;
    if (advance) begin
      pay_d[11].offset = pay_q[10].offset + contrib_q;
      pay_d[11].w      = nxt_dim(pay_q[10].w, pay_q[10].up);
      pay_d[11].h      = nxt_dim(pay_q[10].h, pay_q[10].up);
      if (pay_q[10].is_3d) begin
        pay_d[11].d = DEP_W'(nxt_dim(DIM_W'(pay_q[10].d), pay_q[10].up));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q     <= pay_d;
    y1_q      <= y1_d;
    pl_q      <= pl_d;
    ph_q      <= ph_d;
    y2_q      <= y2_d;
    dl_q      <= dl_d;
    dh_q      <= dh_d;
    contrib_q <= contrib_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CELL_STAGES-2:0], vld_i};
    end
  end

  assign vld_o  = vld_q[CELL_STAGES-1];
  assign item_o = pay_q[CELL_STAGES-1];

endmodule

// ===== design/mip_level_layout_calc.sv =====
// ----------------------------------------------------------------------------
// mip_level_layout_calc
// Byte offset, row stride and image stride of one level of a mipmapped image.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken at a rising edge with start high and busy low.
//   busy stays low: the level chain is fully pipelined and takes a new request
//   in every cycle.
//   Each request yields one result on rsp_o, marked by done_o for exactly one
//   cycle, in request order.
// The chain has one cell per level, each twelve register stages deep: two
//   three-stage align units plus split multiplies and the offset add.
// Throughput: one request per cycle.
// Reset clears all in-flight requests; no result follows a reset until a new
//   request is taken. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module mip_level_layout_calc #(
  parameter int unsigned ALIGN_BYTES = 16,
  parameter int unsigned MAX_LEVELS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mip_pkg::mip_req_t req_i,
  output logic              done_o,
  output mip_pkg::mip_rsp_t rsp_o
);

  import mip_pkg::*;

  logic      vld  [MAX_LEVELS+1];
  mip_item_t item [MAX_LEVELS+1];
  logic      sat;

  assign busy = 1'b0;
  assign sat  = {2'b00, req_i.level_index} >= 6'(MAX_LEVELS);

  always_comb begin
    vld[0]         = start && !busy;
    item[0].w      = DIM_W'(req_i.width);
    item[0].h      = DIM_W'(req_i.height);
    item[0].d      = DEP_W'(req_i.depth);
    item[0].bpt    = req_i.bytes_per_texel;
    item[0].lvl    = sat ? LVL_W'(MAX_LEVELS - 1) : req_i.level_index;
    item[0].is_3d  = req_i.is_3d;
    item[0].up     = req_i.upsampled;
    item[0].offset = '0;
    item[0].row    = '0;
    item[0].img    = '0;
  end

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    mip_cell #(
      .ALIGN_BYTES (ALIGN_BYTES),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .item_i (item[g]),
      .vld_o  (vld[g+1]),
      .item_o (item[g+1])
    );
  end

  assign done_o             = vld[MAX_LEVELS];
  assign rsp_o.level_offset = item[MAX_LEVELS].offset;
  assign rsp_o.row_stride   = item[MAX_LEVELS].row;
  assign rsp_o.image_stride = item[MAX_LEVELS].img;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for mip_level_layout_calc. A short table of directed requests
// covers extremes, zero dimensions and both scaling modes. A long stream of
// random requests follows. Results are checked in order with typed rows or
// a level-chain predictor. The sender idles in random bursts, drains twice.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mip_pkg::*;

  localparam int unsigned ALIGN_BYTES = 16;
  localparam int unsigned MAX_LEVELS  = 16;
  localparam int unsigned RAND_REQS   = 1750;
  localparam int unsigned QUIET_TAIL  = 200;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE      = 12 * MAX_LEVELS + 20;

  typedef struct {
    mip_req_t req;
    bit       typed;
    mip_rsp_t rsp;
  } dir_row_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  mip_req_t req_i  = '0;
  logic     done_o;
  mip_rsp_t rsp_o;

  mip_rsp_t    pending_layouts[$];
  dir_row_t    dir_rows[$];
  int unsigned err_cnt = 0;

  always #4 clk_i = ~clk_i;

  mip_level_layout_calc #(
    .ALIGN_BYTES(ALIGN_BYTES),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  function automatic logic [63:0] align_up(logic [63:0] x);
    logic [63:0] a;
    a = 64'(ALIGN_BYTES);
    return ((x + (a - 64'd1)) / a) * a;
  endfunction

  function automatic logic [63:0] scale_dim(logic [63:0] v, bit up);
    logic [63:0] n;
    n = up ? (v << 1) : (v >> 1);
    return (n == 64'd0) ? 64'd1 : n;
  endfunction

  function automatic mip_rsp_t calc_level_layout(mip_req_t r);
    logic [63:0] w, h, d, bpt, offset, row, img;
    int unsigned lvl;
    mip_rsp_t    res;
    w      = 64'(r.width);
    h      = 64'(r.height);
    d      = 64'(r.depth);
    bpt    = 64'(r.bytes_per_texel);
    lvl    = 32'(r.level_index);
    offset = 64'd0;
    if (lvl >= MAX_LEVELS) begin
      lvl = MAX_LEVELS - 1;
    end
    for (int unsigned i = 0; i < lvl; i++) begin
      row    = align_up(w * bpt);
      img    = align_up(h * row);
      offset = offset + d * img;
      w      = scale_dim(w, r.upsampled);
      h      = scale_dim(h, r.upsampled);
      if (r.is_3d) begin
        d = scale_dim(d, r.upsampled);
      end
    end
    res.row_stride   = align_up(w * bpt);
    res.image_stride = align_up(h * res.row_stride);
    res.level_offset = offset;
    return res;
  endfunction

  function automatic mip_req_t mk_req(int unsigned w, int unsigned h, int unsigned d,
                                      int unsigned bpt, int unsigned lvl,
                                      int unsigned is_3d, int unsigned up);
    mip_req_t r;
    r.width           = 15'(w);
    r.height          = 15'(h);
    r.depth           = 12'(d);
    r.bytes_per_texel = 5'(bpt);
    r.level_index     = 4'(lvl);
    r.is_3d           = 1'(is_3d);
    r.upsampled       = 1'(up);
    return r;
  endfunction

  function automatic mip_rsp_t mk_rsp(logic [63:0] offset, logic [63:0] row,
                                      logic [63:0] img);
    mip_rsp_t r;
    r.level_offset = offset;
    r.row_stride   = row;
    r.image_stride = img;
    return r;
  endfunction

  function automatic mip_req_t rand_req();
    mip_req_t    r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      r = mk_req($urandom_range(1, 16384), $urandom_range(1, 16384), $urandom_range(1, 2048),
                 $urandom_range(1, 16), $urandom_range(0, 15), $urandom_range(0, 1),
                 $urandom_range(0, 1));
    end else if (mode < 8) begin
      r = mip_req_t'($urandom());
      r.width  = 15'($urandom());
      r.height = 15'($urandom());
    end else begin
      r = mk_req($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 2),
                 $urandom_range(0, 1) ? 31 : $urandom_range(0, 2), $urandom_range(0, 15),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        r.width  = 15'h7FFF;
        r.height = 15'h7FFF;
        r.depth  = 12'hFFF;
      end
    end
    return r;
  endfunction

  task automatic issue(mip_req_t r, bit typed, mip_rsp_t rsp);
    bit took;
    took = 1'b0;
    start <= 1'b1;
    req_i <= r;
    while (!took) begin
      @(negedge clk_i);
      if (!busy) begin
        took = 1'b1;
        pending_layouts.push_back(typed ? rsp : calc_level_layout(r));
      end
      @(posedge clk_i);
    end
  endtask

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    req_i <= mip_req_t'($urandom());
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_layouts.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    mip_rsp_t exp;
    if (rst_ni && done_o) begin
      if (pending_layouts.size() == 0) begin
        $error("unexpected result: level_offset %0h", rsp_o.level_offset);
        err_cnt++;
      end else begin
        exp = pending_layouts.pop_front();
        if (rsp_o.level_offset !== exp.level_offset) begin
          $error("level_offset: expected %0h, got %0h", exp.level_offset, rsp_o.level_offset);
          err_cnt++;
        end
        if (rsp_o.row_stride !== exp.row_stride) begin
          $error("row_stride: expected %0h, got %0h", exp.row_stride, rsp_o.row_stride);
          err_cnt++;
        end
        if (rsp_o.image_stride !== exp.image_stride) begin
          $error("image_stride: expected %0h, got %0h", exp.image_stride, rsp_o.image_stride);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("mip_level_layout_calc test failed");
    $finish;
  end

  initial begin
    int unsigned gap_pct;
    int unsigned waited;
    mip_rsp_t    none;
    none = '0;

    // directed table: typed expectations only where obvious
    dir_rows.push_back('{mk_req(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0)});
    dir_rows.push_back('{mk_req(1, 1, 1, 1, 0, 0, 0), 1'b1, mk_rsp(0, 16, 16)});
    dir_rows.push_back('{mk_req(1, 1, 1, 1, 1, 0, 0), 1'b1, mk_rsp(16, 16, 16)});
    dir_rows.push_back('{mk_req(16, 4, 1, 4, 0, 1, 0), 1'b1, mk_rsp(0, 64, 256)});
    dir_rows.push_back('{mk_req(5, 3, 7, 3, 0, 0, 1), 1'b1, mk_rsp(0, 16, 48)});
    dir_rows.push_back('{mk_req(0, 0, 0, 0, 15, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(0, 0, 0, 0, 15, 1, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(0, 9, 3, 4, 3, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(9, 0, 0, 4, 3, 0, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(16384, 16384, 2048, 16, 15, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(16384, 16384, 2048, 16, 15, 1, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(16384, 16384, 2048, 16, 15, 0, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(32767, 32767, 4095, 31, 15, 1, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(32767, 32767, 4095, 31, 15, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(32767, 32767, 4095, 31, 0, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(1, 1, 1, 1, 15, 1, 1), 1'b0, none});
    dir_rows.push_back('{mk_req(1, 1, 1, 1, 15, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(3, 16384, 1, 7, 8, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(16384, 3, 2048, 13, 12, 1, 0), 1'b0, none});
    dir_rows.push_back('{mk_req(100, 50, 8, 2, 5, 1, 1), 1'b0, none});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      if ($urandom_range(0, 2) == 0) begin
        idle_for($urandom_range(1, 6));
      end
    end
    drain_pipeline();

    gap_pct = 30;
    for (int unsigned n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 0) begin
        gap_pct = $urandom_range(0, 2) * 30;
      end
      if (n == RAND_REQS / 2) begin
        drain_pipeline();
      end
      issue(rand_req(), 1'b0, none);
      if (n < RAND_REQS - QUIET_TAIL && $urandom_range(0, 99) < gap_pct) begin
        idle_for($urandom_range(1, 6));
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_layouts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_layouts.size() != 0) begin
      $error("%0d results never arrived", pending_layouts.size());
      err_cnt++;
    end
    repeat (SETTLE) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("mip_level_layout_calc test passed");
    end else begin
      $display("mip_level_layout_calc test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mip_pkg.sv
design/mip_rnd.sv
design/mip_cell.sv
design/mip_level_layout_calc.sv
bench/tb.sv
